>>> hw/rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial division prime test block.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int DEF_WIDTH      = 16;
  // remainder bits resolved per divide cycle
  localparam int RADIX_BITS     = 4;
  // first trial divisor
  localparam int FIRST_DIVISOR  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_TEST,
    ST_FINISH
  } tdpt_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic next_div;
    logic set_result;
    logic result_prime;
    logic write_out;
  } tdpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cand_lt2;
    logic sq_gt_cand;
    logic rem_zero;
    logic div_last;
    logic out_free;
  } tdpt_stat_t;

endpackage

>>> hw/rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for the trial divisor loop: load, bound check, divide, test, hand off.
// ----------------------------------------------------------------------------
module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tdpt_stat_t stat,
  output tdpt_cmd_t  cmd
);

  tdpt_state_t state_r;
  tdpt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (stat.cand_lt2) begin
          cmd.set_result   = 1'b1;
          cmd.result_prime = 1'b0;
          state_nxt        = ST_FINISH;
        end else if (stat.sq_gt_cand) begin
          cmd.set_result   = 1'b1;
          cmd.result_prime = 1'b1;
          state_nxt        = ST_FINISH;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat.rem_zero) begin
          cmd.set_result   = 1'b1;
          cmd.result_prime = 1'b0;
          state_nxt        = ST_FINISH;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.write_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/tdpt_dpath.sv
// ----------------------------------------------------------------------------
// tdpt_dpath
// Candidate, divisor and square registers, radix-16 remainder unit,
// prime tally and output register.
// ----------------------------------------------------------------------------
module tdpt_dpath
  import tdpt_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] in_candidate,
  input  tdpt_cmd_t        cmd,
  output tdpt_stat_t       stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_prime,
  output logic [WIDTH-1:0] out_primes_so_far
);

  localparam int DW    = (WIDTH + 1) / 2 + 1;
  localparam int SW    = 2 * DW;
  localparam int STEPS = (WIDTH + RADIX_BITS - 1) / RADIX_BITS;
  localparam int PW    = STEPS * RADIX_BITS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [WIDTH-1:0] cand_r;
  logic [DW-1:0]    div_r;
  logic [SW-1:0]    sq_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    rem_nxt;
  logic [PW-1:0]    dvd_r;
  logic [CW-1:0]    cnt_r;
  logic             prime_r;
  logic             out_valid_r;
  logic             out_prime_r;
  logic [WIDTH-1:0] tally_r;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [DW:0] t;
    rem_nxt = rem_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      t = {rem_nxt, dvd_r[PW-1-i]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_nxt = t[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_r <= in_candidate;
      div_r  <= DW'(FIRST_DIVISOR);
      sq_r   <= SW'(FIRST_DIVISOR * FIRST_DIVISOR);
    end else if (cmd.next_div) begin
      div_r <= div_r + DW'(1);
      // (d+1)^2 = d^2 + 2d + 1
      sq_r  <= sq_r + SW'({div_r, 1'b1});
    end
    if (cmd.start_div) begin
      rem_r <= '0;
      dvd_r <= PW'(cand_r);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << RADIX_BITS;
    end
    if (cmd.set_result) begin
      prime_r <= cmd.result_prime;
    end
    if (cmd.write_out) begin
      out_prime_r <= prime_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      tally_r     <= '0;
    end else begin
      if (cmd.start_div) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.write_out) begin
        out_valid_r <= 1'b1;
        if (prime_r && (tally_r != '1)) begin
          tally_r <= tally_r + WIDTH'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.cand_lt2   = (cand_r < WIDTH'(2));
  assign stat.sq_gt_cand = (sq_r > SW'(cand_r));
  assign stat.rem_zero   = (rem_r == '0);
  assign stat.div_last   = (cnt_r == CW'(STEPS - 1));
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_is_prime      = out_prime_r;
  assign out_primes_so_far = tally_r;

endmodule

>>> hw/rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Tests one unsigned candidate per transaction for primality by trial
// division and keeps a saturating count of primes seen.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries in_candidate (WIDTH bits)
//   result channel out_valid/out_ready carries out_is_prime and
//   out_primes_so_far, the prime count including this transaction
//   one result per input transaction, in order
// timing:
//   one candidate is worked on at a time; a trial is one bound check,
//   a pass through the shared 4-bit-per-cycle remainder unit and one
//   zero test; 0 and 1 end at the first bound check, a prime when the
//   square passes the candidate, a composite at its first exact divisor
//   for WIDTH = 16, a large prime runs 254 trials
//   the next candidate is taken the cycle after the result is written
// reset:
//   rst_n low clears the controller, the output valid and the count
// stall:
//   the output register holds a finished result until taken; the next
//   candidate is taken and worked on while that result still waits
// ----------------------------------------------------------------------------
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_candidate,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_prime,
  output logic [WIDTH-1:0] out_primes_so_far
);

  // command and status between sequencer and datapath
  tdpt_cmd_t  cmd;
  tdpt_stat_t stat;

  // sequencer: accept, bound check, divide, remainder test, hand off
  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: divisor, exact square bound, remainder unit, tally
  tdpt_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_candidate      (in_candidate),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_prime      (out_is_prime),
    .out_primes_so_far (out_primes_so_far)
  );

endmodule

>>> hw/rtl/tdpt_chk.sv
// ----------------------------------------------------------------------------
// tdpt_chk
// Port-level checks for the trial division prime test block.
// ----------------------------------------------------------------------------
module tdpt_chk
  import tdpt_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_is_prime,
  input logic [WIDTH-1:0] out_primes_so_far
);

  // count carried by the last delivered result
  logic [WIDTH-1:0] last_cnt_r;
  logic [WIDTH-1:0] exp_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
    end else if (out_valid && out_ready) begin
      last_cnt_r <= out_primes_so_far;
    end
  end

  assign exp_cnt = (out_is_prime && (last_cnt_r != '1)) ? last_cnt_r + WIDTH'(1)
                                                         : last_cnt_r;

  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_prime)
                                && $stable(out_primes_so_far))
    else $error("stalled result changed");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> out_primes_so_far == exp_cnt)
    else $error("prime count does not follow delivered results");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second candidate taken while one is in work");

  a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_prime |-> out_primes_so_far != '0)
    else $error("prime result with zero count");

endmodule

bind trial_division_prime_test tdpt_chk #(
  .WIDTH (WIDTH)
) u_tdpt_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_is_prime      (out_is_prime),
  .out_primes_so_far (out_primes_so_far)
);
